[sv/mstd_pkg.sv]
package mstd_pkg;

  // Field widths of the track decoder.
  localparam int unsigned CharW   = 5;
  localparam int unsigned AsciiW  = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned PhaseW  = 2;

  // Default for the top-level parameter.
  localparam int unsigned MAX_TRACK_CHARS_DEF = 107;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] MIN_CHARS_RST = 7'd16;
  localparam logic [CountW-1:0] MAX_CHARS_RST = 7'd40;

  // Configuration register indexes.
  localparam logic CFG_MIN_CHARS = 1'b0;
  localparam logic CFG_MAX_CHARS = 1'b1;

  // Decoder phases.
  localparam logic [PhaseW-1:0] PH_HUNT    = 2'd0;
  localparam logic [PhaseW-1:0] PH_COLLECT = 2'd1;
  localparam logic [PhaseW-1:0] PH_END     = 2'd2;

  // Character constants.
  localparam logic [CharW-1:0]  START_SENTINEL = 5'h0B;
  localparam logic [CharW-1:0]  END_SENTINEL   = 5'h1F;
  localparam logic [AsciiW-1:0] ASCII_OFFSET   = 7'h30;
  localparam logic [IdxW-1:0]   BITS_PER_CHAR  = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_CHAR    = 3'd0;
  localparam logic [StatusW-1:0] ST_OK      = 3'd1;
  localparam logic [StatusW-1:0] ST_PARITY  = 3'd2;
  localparam logic [StatusW-1:0] ST_LENGTH  = 3'd3;
  localparam logic [StatusW-1:0] ST_NOSTART = 3'd4;
  localparam logic [StatusW-1:0] ST_NODATA  = 3'd5;

  // Decoder state carried from one bit to the next.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [IdxW-1:0]   bit_index;
    logic [CharW-1:0]  char_shift;
    logic [CountW-1:0] char_count;
  } dec_state_t;

  // One result as produced by the step logic.
  typedef struct packed {
    logic               have;
    logic [CharW-1:0]   char_code;
    logic [AsciiW-1:0]  ascii_char;
    logic [StatusW-1:0] status;
    logic               last;
  } dec_result_t;

endpackage

[sv/mstd_step.sv]
module mstd_step
  import mstd_pkg::*;
#(
  parameter int unsigned MaxTrackChars = MAX_TRACK_CHARS_DEF
) (
  input  dec_state_t        state_i,
  input  logic              raw_bit_i,
  input  logic              swipe_end_i,
  input  logic [CountW-1:0] min_chars_i,
  input  logic [CountW-1:0] max_chars_i,
  output dec_state_t        state_o,
  output dec_result_t       result_o
);

  localparam logic [CountW-1:0] MaxLimit = CountW'(MaxTrackChars);

  logic              data_bit;
  logic [CountW-1:0] eff_max;
  logic [CharW-1:0]  shift_new;
  logic [IdxW-1:0]   idx_new;
  logic [CountW:0]   count_inc;
  dec_state_t        st;
  dec_result_t       res;

  // The data line is active low.
  assign data_bit  = ~raw_bit_i;
  assign eff_max   = (max_chars_i > MaxLimit) ? MaxLimit : max_chars_i;
  assign shift_new = state_i.char_shift | (CharW'(data_bit) << state_i.bit_index);
  assign idx_new   = state_i.bit_index + 3'd1;
  assign count_inc = {1'b0, state_i.char_count} + 8'd1;

  // Per-bit update of the decoder and the result it causes.
  always_comb begin
    st  = state_i;
    res = '0;

    unique case (state_i.phase)
      PH_HUNT: begin
        // Skip leading zeros; the first one is bit zero of the start sentinel.
        if (data_bit) begin
          st.phase      = PH_COLLECT;
          st.char_shift = 5'd1;
          st.bit_index  = 3'd1;
        end
      end
      PH_COLLECT: begin
        st.char_shift = shift_new;
        st.bit_index  = idx_new;
        if (idx_new >= BITS_PER_CHAR) begin
          st.bit_index  = '0;
          st.char_shift = '0;
          res.have      = 1'b1;
          res.status    = ST_CHAR;
          if (shift_new == '0) begin
            // An all-zero character ends the track without being counted.
            res.last   = 1'b1;
            res.status = (state_i.char_count >= min_chars_i &&
                          state_i.char_count <= eff_max) ? ST_OK : ST_LENGTH;
          end else begin
            res.char_code  = shift_new;
            res.ascii_char = {3'b000, shift_new[3:0]} + ASCII_OFFSET;
            if (state_i.char_count == '0 && shift_new != START_SENTINEL) begin
              res.last   = 1'b1;
              res.status = ST_NOSTART;
            end else if (!(^shift_new)) begin
              res.last   = 1'b1;
              res.status = ST_PARITY;
            end else if (count_inc > {1'b0, eff_max}) begin
              res.last   = 1'b1;
              res.status = ST_LENGTH;
            end else begin
              st.char_count = count_inc[CountW-1:0];
              if (shift_new == END_SENTINEL) begin
                res.last   = 1'b1;
                res.status = (count_inc[CountW-1:0] >= min_chars_i) ? ST_OK : ST_LENGTH;
              end
            end
          end
        end
      end
      default: begin
        // Track has ended; bits are ignored until the swipe ends.
      end
    endcase

    if (swipe_end_i) begin
      // A swipe cut short still closes the track with a verdict.
      if (!res.last && !st.phase[1]) begin
        res.have = 1'b1;
        res.last = 1'b1;
        if (st.phase == PH_HUNT) begin
          res.status = ST_NODATA;
        end else if (st.char_count == '0) begin
          res.status = ST_NOSTART;
        end else begin
          res.status = ST_LENGTH;
        end
      end
      st = '0;
    end else if (res.last) begin
      st.phase      = PH_END;
      st.bit_index  = '0;
      st.char_shift = '0;
    end
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

[sv/magstripe_track_char_decoder.sv]
// Channel   Direction  Payload                                     Transfer
// s_axis    in         tdata[0] raw_bit, tlast swipe_end           tvalid & tready
// m_axis    out        tdata char_code/ascii_char, tuser status,   tvalid & tready
//                      tlast last
// cfg       in         index 0 min_chars, 1 max_chars              cfg_we_i
//
// One raw bit is taken every cycle unless the output stalls; a bit passes an
// input register and the decode logic, and its result (if any) is registered.
// Both stages advance together when the result register is empty or drained.
// A stalled result register holds the input stage; the pipeline holds two bits.
// Reset clears the decoder to hunting and the registers to 16 and 40.
module magstripe_track_char_decoder
  import mstd_pkg::*;
#(
  parameter int unsigned MAX_TRACK_CHARS = MAX_TRACK_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  // Raw track bits.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [0] raw_bit, [7:1] zero
  input  logic               s_axis_tlast,   // swipe_end
  // Decoded characters.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [4:0] char_code, [11:5] ascii_char,
                                             // [15:12] zero
  output logic [StatusW-1:0] m_axis_tuser,   // [2:0] status
  output logic               m_axis_tlast    // last
);

  logic [CountW-1:0] min_chars_q;
  logic [CountW-1:0] max_chars_q;
  logic              in_valid_q, in_valid_d;
  logic              in_bit_q;
  logic              in_end_q;
  logic              out_valid_q, out_valid_d;
  dec_result_t       out_q;
  dec_state_t        state_q;
  dec_state_t        state_d;
  dec_result_t       result;
  logic              s_xfer;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_chars_q <= MIN_CHARS_RST;
      max_chars_q <= MAX_CHARS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_CHARS: min_chars_q <= cfg_wdata_i;
        CFG_MAX_CHARS: max_chars_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  assign in_valid_d = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_bit_q <= s_axis_tdata[0];
      in_end_q <= s_axis_tlast;
    end
  end

  // Per-bit decode.
  mstd_step #(
    .MaxTrackChars(MAX_TRACK_CHARS)
  ) u_step (
    .state_i    (state_q),
    .raw_bit_i  (in_bit_q),
    .swipe_end_i(in_end_q),
    .min_chars_i(min_chars_q),
    .max_chars_i(max_chars_q),
    .state_o    (state_d),
    .result_o   (result)
  );

  // Decoder state moves only when a bit leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  assign out_valid_d = advance ? result.have : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.ascii_char, out_q.char_code};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
  // A character is never gathered past its fifth bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_index < BITS_PER_CHAR)
    else $error("bit index ran past one character");

  // The count never passes the build-time ceiling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.char_count <= CountW'(MAX_TRACK_CHARS))
    else $error("character count above ceiling");

  // Only a plain character result leaves the track open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.status == ST_CHAR) == !out_q.last))
    else $error("status and last disagree");

  // The end of a swipe always returns the decoder to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_end_q |=> state_q == '0)
    else $error("decoder not idle after swipe end");
`endif

endmodule

[tb/magstripe_track_char_decoder_tb.sv]
`timescale 1ns / 100ps

module magstripe_track_char_decoder_tb
  import mstd_pkg::*;
();

  localparam int unsigned TRACK_CAP      = MAX_TRACK_CHARS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PIPE_SETTLE    = 6;
  localparam int unsigned SETTING_BITS   = 105;
  localparam int unsigned NUM_SETTINGS   = 6;
  localparam int unsigned MAX_REPORTS    = 50;

  // One decoded character or verdict as seen on the output stream.
  typedef struct packed {
    logic [CharW-1:0]   code;
    logic [AsciiW-1:0]  ascii;
    logic [StatusW-1:0] status;
    logic               last;
  } char_result_t;

  // Tracks the decoder state, predicts each result and checks what comes out.
  class char_scoreboard;
    logic [CountW-1:0] min_chars;
    logic [CountW-1:0] max_chars;
    logic [PhaseW-1:0] phase;
    logic [IdxW-1:0]   bit_idx;
    logic [CharW-1:0]  shift;
    logic [CountW-1:0] count;
    char_result_t      expected_chars[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      min_chars  = MIN_CHARS_RST;
      max_chars  = MAX_CHARS_RST;
      mismatches = 0;
      checked    = 0;
      clear_track();
    endfunction

    function void clear_track();
      phase   = PH_HUNT;
      bit_idx = '0;
      shift   = '0;
      count   = '0;
    endfunction

    function void set_reg(logic idx, logic [CountW-1:0] value);
      if (idx == CFG_MIN_CHARS) begin
        min_chars = value;
      end else begin
        max_chars = value;
      end
    endfunction

    function int unsigned eff_max();
      return (max_chars > TRACK_CAP) ? TRACK_CAP : int'(max_chars);
    endfunction

    // Advance the predicted decoder by one accepted raw bit.
    function void accept_bit(logic raw, logic fin);
      logic         lbit;
      logic         have;
      logic [CharW-1:0] c;
      char_result_t res;
      lbit = ~raw;
      have = 1'b0;
      res  = '{code: '0, ascii: '0, status: ST_CHAR, last: 1'b0};
      if (phase == PH_HUNT) begin
        if (lbit) begin
          phase   = PH_COLLECT;
          shift   = CharW'(1);
          bit_idx = IdxW'(1);
        end
      end else if (phase == PH_COLLECT) begin
        shift   = shift | (CharW'(lbit) << bit_idx);
        bit_idx = bit_idx + 1'b1;
        if (bit_idx >= BITS_PER_CHAR) begin
          c       = shift;
          bit_idx = '0;
          shift   = '0;
          have    = 1'b1;
          if (c == '0) begin
            // An all-zero character closes the track without being counted.
            res.last   = 1'b1;
            res.status = (count >= min_chars && count <= eff_max()) ? ST_OK : ST_LENGTH;
          end else begin
            res.code  = c;
            res.ascii = ASCII_OFFSET + AsciiW'(c[3:0]);
            if (count == '0 && c != START_SENTINEL) begin
              res.last   = 1'b1;
              res.status = ST_NOSTART;
            end else if (!(^c)) begin
              res.last   = 1'b1;
              res.status = ST_PARITY;
            end else if (int'(count) + 1 > eff_max()) begin
              res.last   = 1'b1;
              res.status = ST_LENGTH;
            end else begin
              count = count + 1'b1;
              if (c == END_SENTINEL) begin
                res.last   = 1'b1;
                res.status = (count >= min_chars) ? ST_OK : ST_LENGTH;
              end
            end
          end
        end
      end

      // A swipe that ends before the track did still gets a closing verdict.
      if (fin) begin
        if (!res.last && (phase == PH_HUNT || phase == PH_COLLECT)) begin
          res.last = 1'b1;
          if (phase == PH_HUNT) begin
            res.status = ST_NODATA;
          end else if (count == '0) begin
            res.status = ST_NOSTART;
          end else begin
            res.status = ST_LENGTH;
          end
          have = 1'b1;
        end
        clear_track();
      end else if (res.last) begin
        phase   = PH_END;
        bit_idx = '0;
        shift   = '0;
      end
      if (have) begin
        expected_chars.push_back(res);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    // Compare one output transfer with the oldest prediction.
    task check_char(logic [15:0] data, logic [StatusW-1:0] user, logic tl);
      char_result_t want;
      char_result_t got;
      got.code   = data[4:0];
      got.ascii  = data[11:5];
      got.status = user;
      got.last   = tl;
      checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result code=%h status=%0d", got.code, got.status));
      end else begin
        want = expected_chars.pop_front();
        if (got.code != want.code) begin
          report_mismatch($sformatf("char_code %h, wanted %h", got.code, want.code));
        end
        if (got.ascii != want.ascii) begin
          report_mismatch($sformatf("ascii_char %h, wanted %h", got.ascii, want.ascii));
        end
        if (got.status != want.status) begin
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        end
        if (got.last != want.last) begin
          report_mismatch($sformatf("last %0d, wanted %0d", got.last, want.last));
        end
      end
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_idx_i     = CFG_MIN_CHARS;
  logic [CountW-1:0]  cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic [StatusW-1:0] m_axis_tuser;
  logic               m_axis_tlast;

  char_scoreboard sb = new();

  // Logical track bits of the swipe being built, oldest first.
  bit          track_bits[$];
  int unsigned snd_idle_pct  = 37;
  int unsigned rcv_idle_pct  = 67;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned bits_sent     = 0;
  int unsigned swipes_sent   = 0;
  int unsigned quiet_cycles  = 0;

  int unsigned set_min[NUM_SETTINGS] = '{2, 1, 0, 9, 127, 3};
  int unsigned set_max[NUM_SETTINGS] = '{6, 1, 5, 3, 127, 127};

  magstripe_track_char_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Observe both streams at each edge and keep a watchdog on progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.accept_bit(s_axis_tdata[0], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_char(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [CharW-1:0] digit_char(logic [3:0] v);
    return {~(^v), v};
  endfunction

  function automatic void add_char(logic [CharW-1:0] c);
    for (int i = 0; i < CharW; i++) begin
      track_bits.push_back(c[i]);
    end
  endfunction

  function automatic void add_bits(int unsigned n, bit random_bits);
    for (int i = 0; i < n; i++) begin
      track_bits.push_back(random_bits ? 1'($urandom_range(1)) : 1'b0);
    end
  endfunction

  // Leading zeros, start sentinel, k digits and a terminating character.
  function automatic void add_good_track(int unsigned k, logic [CharW-1:0] term);
    add_bits($urandom_range(3), 1'b0);
    add_char(START_SENTINEL);
    for (int i = 0; i < k; i++) begin
      add_char(digit_char(4'($urandom_range(15))));
    end
    add_char(term);
  endfunction

  // Offer one raw sample; the sender may idle first. Returns after the transfer.
  task automatic send_bit(logic raw, logic fin);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, raw};
    s_axis_tlast  <= fin;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    bits_sent++;
  endtask

  // Send the built swipe, active low, with swipe end on its last sample.
  task automatic send_swipe();
    for (int i = 0; i < track_bits.size(); i++) begin
      send_bit(~track_bits[i], i == track_bits.size() - 1);
    end
    track_bits.delete();
    swipes_sent++;
  endtask

  // Stop offering, wait for every predicted result and let the pipeline settle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_setting(int unsigned min_v, int unsigned max_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_CHARS;
    cfg_wdata_i <= CountW'(min_v);
    @(posedge clk_i);
    sb.set_reg(CFG_MIN_CHARS, CountW'(min_v));
    cfg_idx_i   <= CFG_MAX_CHARS;
    cfg_wdata_i <= CountW'(max_v);
    @(posedge clk_i);
    sb.set_reg(CFG_MAX_CHARS, CountW'(max_v));
    cfg_we_i    <= 1'b0;
  endtask

  // One random swipe: mostly well-formed tracks, some broken ones and noise.
  task automatic random_swipe();
    int unsigned      kind;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      cut;
    logic [CharW-1:0] c;
    kind = $urandom_range(99);
    hi   = (sb.eff_max() < 20) ? sb.eff_max() : 20;
    lo   = (sb.min_chars > 4) ? sb.min_chars - 4 : 0;
    if (lo > hi) begin
      lo = hi;
    end
    if (kind < 55) begin
      add_good_track($urandom_range(hi, lo),
                     ($urandom_range(4) == 0) ? CharW'(0) : END_SENTINEL);
      add_bits($urandom_range(3), 1'b1);
    end else if (kind < 65) begin
      // A character with even parity somewhere after the start sentinel.
      add_bits($urandom_range(2), 1'b0);
      add_char(START_SENTINEL);
      repeat ($urandom_range(3)) add_char(digit_char(4'($urandom_range(15))));
      c = CharW'($urandom_range(31));
      if (^c) begin
        c[4] = ~c[4];
      end
      add_char(c);
      add_bits($urandom_range(6), 1'b1);
    end else if (kind < 73) begin
      // First character is not the start sentinel.
      add_bits($urandom_range(2), 1'b0);
      c = CharW'($urandom_range(15) * 2 + 1);
      if (c == START_SENTINEL) begin
        c = 5'h0D;
      end
      add_char(c);
      add_bits($urandom_range(8), 1'b1);
    end else if (kind < 88) begin
      // Swipe cut short at a random sample of an otherwise good track.
      add_good_track($urandom_range(hi, lo), END_SENTINEL);
      cut = $urandom_range(track_bits.size(), 1);
      while (track_bits.size() > cut) begin
        void'(track_bits.pop_back());
      end
    end else begin
      add_bits($urandom_range(24, 1), $urandom_range(1));
    end
    send_swipe();
  endtask

  initial begin : stimulus
    int unsigned start_bits;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed swipes at reset settings: no data, a short track with an
    // ignored sample after the end sentinel, and an all-zero terminator.
    add_bits(1, 1'b0);
    send_swipe();
    add_bits(2, 1'b0);
    add_char(START_SENTINEL);
    add_char(END_SENTINEL);
    track_bits.push_back(1'b1);
    send_swipe();
    add_char(START_SENTINEL);
    add_char(CharW'(0));
    send_swipe();
    drain_block();

    // Random swipes under each register setting, sender and receiver idling
    // in turn and then at full rate.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s < 2) begin
        snd_idle_pct = 37;
        rcv_idle_pct = 67;
      end else if (s < 4) begin
        snd_idle_pct = 67;
        rcv_idle_pct = 37;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      apply_setting(set_min[s], set_max[s]);
      if (s == 2) begin
        hold_request = 1'b1;
      end
      if (s == NUM_SETTINGS - 1) begin
        // One full-length track that fills the count to its ceiling.
        add_good_track(sb.eff_max() - 2, END_SENTINEL);
        send_swipe();
      end
      start_bits = bits_sent;
      while (bits_sent - start_bits < SETTING_BITS) begin
        random_swipe();
      end
      drain_block();
    end

    if (sb.expected_chars.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_chars.size()));
    end
    $display("tb: %0d swipes of %0d samples gave %0d results under %0d register settings,",
             swipes_sent, bits_sent, sb.checked, NUM_SETTINGS + 1);
    $display("tb: with idle gaps on both sides, one long output stall and one full track.");
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
